FILE: design/bclru_pkg.sv
// ----------------------------------------------------------------------------
// bclru_pkg
// Shared types and constants of the block cache LRU write-back directory:
// action and status codes, register indexes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bclru_pkg;

   localparam int WAYS_DEF       = 8;
   localparam int INDEX_BITS_DEF = 10;
   localparam int CAP_W          = 4;
   localparam int CNT_W          = 32;
   localparam int ACTION_W       = 2;
   localparam int STATUS_W       = 2;
   localparam int CSR_INDEX_W    = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ        = 2'd0,
      ACT_ELEM_WRITE  = 2'd1,
      ACT_BLOCK_WRITE = 2'd2,
      ACT_FLUSH       = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT       = 2'd0,
      ST_MISS      = 2'd1,
      ST_RANGE_ERR = 2'd2,
      ST_FLUSH     = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd2;

   typedef struct packed {
      logic load;
      logic lookup;
      logic evict_step;
      logic install;
      logic emit_final;
      logic flush_step;
      logic sel_flush;
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic range_fault;
      logic hit;
      logic need_evict;
      logic evict_blocked;
      logic evict_last;
      logic out_free;
      logic flush_last;
   } stat_type;

endpackage

FILE: design/bclru_ctrl.sv
// ----------------------------------------------------------------------------
// bclru_ctrl
// Sequencer of the cache directory: takes one request, runs the lookup,
// the eviction walk, the install or the flush walk, and hands each result
// word to the output register when it has room.
// ----------------------------------------------------------------------------
module bclru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bclru_pkg::stat_type stat,
   output bclru_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EVICT,
      S_INSTALL,
      S_FINAL,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (stat.is_flush) begin
               state_in = S_FLUSH;
            end else if (stat.range_fault || stat.hit) begin
               state_in = S_FINAL;
            end else if (stat.need_evict) begin
               state_in = S_EVICT;
            end else begin
               state_in = S_INSTALL;
            end
         end
         S_EVICT: begin
            // A dirty victim may have to push out the previous one first.
            if (!stat.evict_blocked) begin
               cmd.evict_step = 1'b1;
               if (stat.evict_last) begin
                  state_in = S_INSTALL;
               end
            end
         end
         S_INSTALL: begin
            cmd.install = 1'b1;
            state_in    = S_FINAL;
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_FLUSH: begin
            cmd.sel_flush = 1'b1;
            if (stat.out_free) begin
               cmd.flush_step = 1'b1;
               if (stat.flush_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: design/bclru_dpath.sv
// ----------------------------------------------------------------------------
// bclru_dpath
// Directory datapath: configuration registers, request register, tag,
// dirty and age-rank registers with parallel tag compare, the saturating
// counters, the pending write-back holder and the output register.
// ----------------------------------------------------------------------------
module bclru_dpath #(
   parameter int WAYS       = bclru_pkg::WAYS_DEF,
   parameter int INDEX_BITS = bclru_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bclru_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [((INDEX_BITS + 1 > bclru_pkg::CAP_W) ? INDEX_BITS + 1
                  : bclru_pkg::CAP_W)-1:0]     csr_write_data,
   input  logic [bclru_pkg::ACTION_W-1:0]      req_action,
   input  logic [INDEX_BITS-1:0]               req_block_row_index,
   input  logic [INDEX_BITS-1:0]               req_block_col_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bclru_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                rsp_fill_needed,
   output logic                                rsp_writeback_valid,
   output logic [INDEX_BITS-1:0]               rsp_writeback_row,
   output logic [INDEX_BITS-1:0]               rsp_writeback_col,
   output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] rsp_slot,
   output logic                                rsp_last,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_hits_total,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_misses_total,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_writebacks_total,
   input  bclru_pkg::cmd_type                  cmd,
   output bclru_pkg::stat_type                 stat
);

   localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = SLOT_W;
   localparam int OCC_W  = $clog2(WAYS + 1);
   localparam int LIM_W  = INDEX_BITS + 1;
   localparam int CAP_W  = bclru_pkg::CAP_W;
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int CW     = bclru_pkg::CNT_W;
   localparam int AW     = bclru_pkg::ACTION_W;
   localparam int SW     = bclru_pkg::STATUS_W;
   localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(1) << INDEX_BITS;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
                                             input logic [CW-1:0] k);
      logic [CW:0] s;
      s = {1'b0, c} + {1'b0, k};
      return s[CW] ? {CW{1'b1}} : s[CW-1:0];
   endfunction

   // Configuration.
   logic [LIM_W-1:0] rows_lim_ff, rows_lim_in;
   logic [LIM_W-1:0] cols_lim_ff, cols_lim_in;
   logic [CAP_W-1:0] cap_ff, cap_in;

   // Request.
   logic [AW-1:0]         act_ff, act_in;
   logic [INDEX_BITS-1:0] row_ff, row_in;
   logic [INDEX_BITS-1:0] col_ff, col_in;

   // Directory.
   logic [WAYS-1:0]       valid_ff, valid_in;
   logic [WAYS-1:0]       dirty_ff, dirty_in;
   logic [INDEX_BITS-1:0] tag_row_ff [WAYS];
   logic [INDEX_BITS-1:0] tag_row_in [WAYS];
   logic [INDEX_BITS-1:0] tag_col_ff [WAYS];
   logic [INDEX_BITS-1:0] tag_col_in [WAYS];
   logic [RANK_W-1:0]     rank_ff [WAYS];
   logic [RANK_W-1:0]     rank_in [WAYS];
   logic [OCC_W-1:0]      used_ff, used_in;

   // Per-item working state.
   logic [RANK_W-1:0]     evict_rank_ff, evict_rank_in;
   logic                  pend_ff, pend_in;
   logic [INDEX_BITS-1:0] pend_row_ff, pend_row_in;
   logic [INDEX_BITS-1:0] pend_col_ff, pend_col_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SW-1:0]         class_ff, class_in;

   // Counters.
   logic [CW-1:0] hits_ff, hits_in;
   logic [CW-1:0] misses_ff, misses_in;
   logic [CW-1:0] wbs_ff, wbs_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic [SW-1:0]         out_status_ff, out_status_in;
   logic                  out_fill_ff, out_fill_in;
   logic                  out_wbv_ff, out_wbv_in;
   logic [INDEX_BITS-1:0] out_wr_ff, out_wr_in;
   logic [INDEX_BITS-1:0] out_wc_ff, out_wc_in;
   logic [SLOT_W-1:0]     out_slot_ff, out_slot_in;
   logic                  out_last_ff, out_last_in;
   logic [CW-1:0]         out_hits_ff, out_hits_in;
   logic [CW-1:0]         out_misses_ff, out_misses_in;
   logic [CW-1:0]         out_wbs_ff, out_wbs_in;

   // Lookup logic.
   logic [CMP_W-1:0]      cap_ext, cap_eff, cap_m1, used_ext;
   logic [OCC_W-1:0]      used_m1;
   logic [WAYS-1:0]       match, victim_vec, victim_dirty_vec, flush_vec;
   logic [SLOT_W-1:0]     hit_idx, victim_idx, free_idx, flush_idx, rd_idx;
   logic [RANK_W-1:0]     hit_rank;
   logic [OCC_W-1:0]      victim_dirty_cnt, flush_cnt;
   logic                  hit, range_fault, victim_dirty, out_free, flush_any;
   logic                  flush_last;
   logic                  evict_emit;
   logic [INDEX_BITS-1:0] rd_row, rd_col;

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(WAYS)) begin
         cap_eff = CMP_W'(WAYS);
      end else begin
         cap_eff = cap_ext;
      end
      cap_m1   = cap_eff - CMP_W'(1);
      used_ext = CMP_W'(used_ff);
      used_m1  = used_ff - OCC_W'(1);

      range_fault = ({1'b0, row_ff} >= rows_lim_ff) || ({1'b0, col_ff} >= cols_lim_ff);

      hit_idx          = '0;
      victim_idx       = '0;
      free_idx         = '0;
      flush_idx        = '0;
      hit_rank         = '0;
      victim_dirty_cnt = '0;
      flush_cnt        = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (tag_row_ff[i] == row_ff) && (tag_col_ff[i] == col_ff);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == evict_rank_ff);
         // Entries at or above rank capacity-1 are the ones a miss evicts.
         victim_dirty_vec[i] = valid_ff[i] && dirty_ff[i] &&
                               (CMP_W'(rank_ff[i]) >= cap_m1);
         flush_vec[i] = valid_ff[i] && dirty_ff[i];
         if (match[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
         if (flush_vec[i]) begin
            flush_idx = SLOT_W'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         hit_rank         = hit_rank | (match[i] ? rank_ff[i] : '0);
         victim_dirty_cnt = victim_dirty_cnt + OCC_W'(victim_dirty_vec[i]);
         flush_cnt        = flush_cnt + OCC_W'(flush_vec[i]);
      end
      hit          = |match;
      victim_dirty = |(victim_vec & dirty_ff);
      flush_any    = |flush_vec;
      // True with no dirty block left or exactly one.
      flush_last   = (flush_vec & (flush_vec - WAYS'(1))) == '0;
      out_free     = !out_valid_ff || rsp_ready;
      evict_emit   = cmd.evict_step && victim_dirty && pend_ff;
      rd_idx       = cmd.sel_flush ? flush_idx : victim_idx;
      rd_row       = tag_row_ff[rd_idx];
      rd_col       = tag_col_ff[rd_idx];

      stat.is_flush      = (act_ff == bclru_pkg::ACT_FLUSH);
      stat.range_fault   = range_fault;
      stat.hit           = hit;
      stat.need_evict    = used_ext >= cap_eff;
      stat.evict_blocked = victim_dirty && pend_ff && !out_free;
      stat.evict_last    = CMP_W'(evict_rank_ff) == cap_m1;
      stat.out_free      = out_free;
      stat.flush_last    = flush_last;
   end

   always_comb begin
      rows_lim_in   = rows_lim_ff;
      cols_lim_in   = cols_lim_ff;
      cap_in        = cap_ff;
      act_in        = act_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      tag_row_in    = tag_row_ff;
      tag_col_in    = tag_col_ff;
      rank_in       = rank_ff;
      used_in       = used_ff;
      evict_rank_in = evict_rank_ff;
      pend_in       = pend_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_slot_in  = pend_slot_ff;
      slot_in       = slot_ff;
      class_in      = class_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      wbs_in        = wbs_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_fill_in   = out_fill_ff;
      out_wbv_in    = out_wbv_ff;
      out_wr_in     = out_wr_ff;
      out_wc_in     = out_wc_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      out_hits_in   = out_hits_ff;
      out_misses_in = out_misses_ff;
      out_wbs_in    = out_wbs_ff;

      if (csr_write_enable) begin
         case (csr_index)
            bclru_pkg::CSR_ROWS:     rows_lim_in = csr_write_data[LIM_W-1:0];
            bclru_pkg::CSR_COLS:     cols_lim_in = csr_write_data[LIM_W-1:0];
            bclru_pkg::CSR_CAPACITY: cap_in = csr_write_data[CAP_W-1:0];
            default: begin
            end
         endcase
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // Any word loaded below carries the counters as they stand after
      // the lookup, which already accounts for the whole item.
      if (evict_emit || cmd.emit_final || cmd.flush_step) begin
         out_fill_in   = 1'b0;
         out_wbv_in    = 1'b0;
         out_wr_in     = '0;
         out_wc_in     = '0;
         out_slot_in   = '0;
         out_last_in   = 1'b1;
         out_hits_in   = hits_ff;
         out_misses_in = misses_ff;
         out_wbs_in    = wbs_ff;
      end

      if (cmd.load) begin
         act_in = req_action;
         row_in = req_block_row_index;
         col_in = req_block_col_index;
      end

      if (cmd.lookup) begin
         evict_rank_in = used_m1[RANK_W-1:0];
         pend_in       = 1'b0;
         if (act_ff == bclru_pkg::ACT_FLUSH) begin
            wbs_in = sat_add(wbs_ff, CW'(flush_cnt));
         end else if (range_fault) begin
            class_in = bclru_pkg::ST_RANGE_ERR;
         end else if (hit) begin
            class_in = bclru_pkg::ST_HIT;
            slot_in  = hit_idx;
            for (int i = 0; i < WAYS; i++) begin
               if (SLOT_W'(i) == hit_idx) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            if (act_ff != bclru_pkg::ACT_READ) begin
               dirty_in[hit_idx] = 1'b1;
            end
            if (act_ff != bclru_pkg::ACT_BLOCK_WRITE) begin
               hits_in = sat_add(hits_ff, CW'(1));
            end
         end else begin
            class_in = bclru_pkg::ST_MISS;
            if (act_ff != bclru_pkg::ACT_BLOCK_WRITE) begin
               misses_in = sat_add(misses_ff, CW'(1));
            end
            wbs_in = sat_add(wbs_ff, CW'(victim_dirty_cnt));
         end
      end

      if (cmd.evict_step) begin
         if (victim_dirty) begin
            // The previous dirty victim goes out now; this one waits, since
            // the last of them rides on the final miss word.
            if (pend_ff) begin
               out_valid_in  = 1'b1;
               out_status_in = bclru_pkg::ST_MISS;
               out_wbv_in    = 1'b1;
               out_wr_in     = pend_row_ff;
               out_wc_in     = pend_col_ff;
               out_slot_in   = pend_slot_ff;
               out_last_in   = 1'b0;
            end
            pend_in      = 1'b1;
            pend_row_in  = rd_row;
            pend_col_in  = rd_col;
            pend_slot_in = victim_idx;
         end
         valid_in[victim_idx] = 1'b0;
         dirty_in[victim_idx] = 1'b0;
         used_in              = used_ff - OCC_W'(1);
         evict_rank_in        = evict_rank_ff - RANK_W'(1);
      end

      if (cmd.install) begin
         for (int i = 0; i < WAYS; i++) begin
            if (SLOT_W'(i) == free_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         valid_in[free_idx]   = 1'b1;
         dirty_in[free_idx]   = (act_ff != bclru_pkg::ACT_READ);
         tag_row_in[free_idx] = row_ff;
         tag_col_in[free_idx] = col_ff;
         used_in              = used_ff + OCC_W'(1);
         slot_in              = free_idx;
      end

      if (cmd.emit_final) begin
         out_valid_in  = 1'b1;
         out_status_in = class_ff;
         if (class_ff == bclru_pkg::ST_HIT) begin
            out_slot_in = slot_ff;
         end else if (class_ff == bclru_pkg::ST_MISS) begin
            out_slot_in = slot_ff;
            out_fill_in = (act_ff == bclru_pkg::ACT_READ);
            out_wbv_in  = pend_ff;
            out_wr_in   = pend_ff ? pend_row_ff : '0;
            out_wc_in   = pend_ff ? pend_col_ff : '0;
         end
      end

      if (cmd.flush_step) begin
         out_valid_in  = 1'b1;
         out_status_in = bclru_pkg::ST_FLUSH;
         if (flush_any) begin
            out_wbv_in          = 1'b1;
            out_wr_in           = rd_row;
            out_wc_in           = rd_col;
            out_slot_in         = flush_idx;
            out_last_in         = flush_last;
            dirty_in[flush_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_lim_ff  <= LIM_RESET;
         cols_lim_ff  <= LIM_RESET;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         wbs_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WAYS; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         rows_lim_ff  <= rows_lim_in;
         cols_lim_ff  <= cols_lim_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         wbs_ff       <= wbs_in;
         out_valid_ff <= out_valid_in;
         rank_ff      <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      tag_row_ff    <= tag_row_in;
      tag_col_ff    <= tag_col_in;
      evict_rank_ff <= evict_rank_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_slot_ff  <= pend_slot_in;
      slot_ff       <= slot_in;
      class_ff      <= class_in;
      out_status_ff <= out_status_in;
      out_fill_ff   <= out_fill_in;
      out_wbv_ff    <= out_wbv_in;
      out_wr_ff     <= out_wr_in;
      out_wc_ff     <= out_wc_in;
      out_slot_ff   <= out_slot_in;
      out_last_ff   <= out_last_in;
      out_hits_ff   <= out_hits_in;
      out_misses_ff <= out_misses_in;
      out_wbs_ff    <= out_wbs_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_fill_needed      = out_fill_ff;
   assign rsp_writeback_valid  = out_wbv_ff;
   assign rsp_writeback_row    = out_wr_ff;
   assign rsp_writeback_col    = out_wc_ff;
   assign rsp_slot             = out_slot_ff;
   assign rsp_last             = out_last_ff;
   assign rsp_hits_total       = out_hits_ff;
   assign rsp_misses_total     = out_misses_ff;
   assign rsp_writebacks_total = out_wbs_ff;

endmodule

FILE: design/block_cache_lru_writeback_unit.sv
// ----------------------------------------------------------------------------
// block_cache_lru_writeback_unit
// Tag directory of a fully associative write-back block cache with LRU
// replacement.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req_*) names an action and a block; it is taken when
// req_valid and req_ready are both high. Each request produces one or more
// result words on rsp_*, the final one marked by rsp_last. A miss may first
// emit words for dirty victims; a flush emits one word per dirty block, or
// a single word if none is dirty. The block works on one request at a time.
// A hit or an out-of-range access goes from the lookup to its final word; a
// miss runs the eviction walk when the directory is at capacity, then the
// install, then its final word. The next request is accepted the cycle
// after the final word is loaded, so a waiting result does not hold off the
// next request. The per-item cost is set by the parallel lookup and the
// eviction and flush walks, one entry per cycle unless a word waits for room.
// When the receiver holds rsp_ready low, the result sits in the output
// register and any further word of the same request waits behind it.
// Reset empties the directory, clears the counters and restores the
// configuration to the full grid and capacity 8, at most WAYS. The user
// must write configuration via csr_* only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
module block_cache_lru_writeback_unit #(
   parameter int WAYS       = bclru_pkg::WAYS_DEF,
   parameter int INDEX_BITS = bclru_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bclru_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [((INDEX_BITS + 1 > bclru_pkg::CAP_W) ? INDEX_BITS + 1
                  : bclru_pkg::CAP_W)-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bclru_pkg::ACTION_W-1:0]      req_action,
   input  logic [INDEX_BITS-1:0]               req_block_row_index,
   input  logic [INDEX_BITS-1:0]               req_block_col_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bclru_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                rsp_fill_needed,
   output logic                                rsp_writeback_valid,
   output logic [INDEX_BITS-1:0]               rsp_writeback_row,
   output logic [INDEX_BITS-1:0]               rsp_writeback_col,
   output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] rsp_slot,
   output logic                                rsp_last,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_hits_total,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_misses_total,
   output logic [bclru_pkg::CNT_W-1:0]         rsp_writebacks_total
);

   bclru_pkg::cmd_type  cmd;
   bclru_pkg::stat_type stat;

   bclru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bclru_dpath #(
      .WAYS       (WAYS),
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_action           (req_action),
      .req_block_row_index  (req_block_row_index),
      .req_block_col_index  (req_block_col_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_fill_needed      (rsp_fill_needed),
      .rsp_writeback_valid  (rsp_writeback_valid),
      .rsp_writeback_row    (rsp_writeback_row),
      .rsp_writeback_col    (rsp_writeback_col),
      .rsp_slot             (rsp_slot),
      .rsp_last             (rsp_last),
      .rsp_hits_total       (rsp_hits_total),
      .rsp_misses_total     (rsp_misses_total),
      .rsp_writebacks_total (rsp_writebacks_total),
      .cmd                  (cmd),
      .stat                 (stat)
   );

endmodule
